/* hdl/qpr_pkg.sv */
`timescale 1ns / 1ps

package qpr_pkg;

	// Default ring depth
	localparam int DEPTH_DEF = 1024;

	// Field widths
	localparam int VALUE_W  = 32;
	localparam int K_W      = 11;
	localparam int OCC_W    = 11;
	localparam int STATUS_W = 2;
	localparam int MODE_W   = 2;

	// Packed bus widths, rounded up to whole bytes
	localparam int IN_TDATA_W  = ((VALUE_W + K_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((VALUE_W + STATUS_W + OCC_W + 7) / 8) * 8;
	localparam int IN_PAD_W    = IN_TDATA_W - VALUE_W - K_W;
	localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - STATUS_W - OCC_W;

	// Command queue between front and back
	localparam int CMDQ_DEPTH = 2;

	// Command codes on the input tuser
	localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

	// Decoded operations
	typedef enum logic [1:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_REVERSE,
		OP_NOP
	} op_t;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_EXCEED   = 2'd3;

	// One classified request
	typedef struct packed {
		op_t                      op;
		logic signed [VALUE_W-1:0] value;
		logic [K_W-1:0]           count;
		logic                     count_zero;
	} cmd_t;

endpackage

/* hdl/qpr_front.sv */
`timescale 1ns / 1ps

module qpr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [qpr_pkg::IN_TDATA_W-1:0] s_tdata, // value, reverse_count, zero pad
	input  logic [qpr_pkg::MODE_W-1:0]     s_tuser, // mode
	output logic                          cmd_valid,
	input  logic                          cmd_ready,
	output qpr_pkg::cmd_t                 cmd
);
	import qpr_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t decoded;

	// Classify the incoming request
	always_comb begin
		decoded.value      = s_tdata[VALUE_W-1:0];
		decoded.count      = s_tdata[VALUE_W +: K_W];
		decoded.count_zero = (s_tdata[VALUE_W +: K_W] == '0);
		unique case (s_tuser)
			MODE_INSERT:  decoded.op = OP_INSERT;
			MODE_REMOVE:  decoded.op = OP_REMOVE;
			MODE_REVERSE: decoded.op = OP_REVERSE;
			MODE_UNUSED:  decoded.op = OP_NOP;
			default:      decoded.op = OP_NOP;
		endcase
	end

	assign s_tready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	// Hold the request until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= decoded;
		end
	end

endmodule

/* hdl/qpr_cmd_fifo.sv */
`timescale 1ns / 1ps

module qpr_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  qpr_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output qpr_pkg::cmd_t out_cmd
);
	import qpr_pkg::*;

	localparam int IW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int NW = $clog2(CMDQ_DEPTH + 1);

	cmd_t           entry_q [CMDQ_DEPTH];
	logic [IW-1:0]  wr_ptr_q;
	logic [IW-1:0]  rd_ptr_q;
	logic [NW-1:0]  fill_q;
	logic           push;
	logic           pop;

	assign in_ready  = (fill_q != NW'(CMDQ_DEPTH));
	assign out_valid = (fill_q != '0);
	assign out_cmd   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + IW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + IW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + NW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

	// Store the request
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

/* hdl/qpr_engine.sv */
`timescale 1ns / 1ps

module qpr_engine #(
	parameter int DEPTH = qpr_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  qpr_pkg::cmd_t                  cmd,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [qpr_pkg::OUT_TDATA_W-1:0] m_tdata // removed_value, status, occupancy, zero pad
);
	import qpr_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = (CW > K_W) ? CW : K_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RDATA = 2'd1;
	localparam logic [1:0] S_PUSH  = 2'd2;
	localparam logic [1:0] S_POP   = 2'd3;

	function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
		adv = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// Memories
	logic [VALUE_W-1:0] ring_mem  [DEPTH];
	logic [VALUE_W-1:0] stack_mem [DEPTH];
	logic [VALUE_W-1:0] ring_rdata_q;
	logic [VALUE_W-1:0] stack_rdata_q;

	// Control state
	logic [1:0]    state_q, state_nxt;
	logic [PW-1:0] head_q, head_nxt;
	logic [PW-1:0] tail_q, tail_nxt;
	logic [CW-1:0] count_q, count_nxt;
	logic [CW-1:0] left_q, left_nxt;
	logic [CW-1:0] sp_q, sp_nxt;
	logic          rdv_s1, rdv_nxt;

	// Output register
	logic                out_valid_q;
	logic [VALUE_W-1:0]  out_removed_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [OCC_W-1:0]    out_occ_q;
	logic                out_free;
	logic                load_out;
	logic [VALUE_W-1:0]  res_removed;
	logic [STATUS_W-1:0] res_status;

	// Memory port controls
	logic                ring_we, ring_re, stack_we, stack_re;
	logic [PW-1:0]       ring_waddr, ring_raddr, stack_waddr, stack_raddr;
	logic [VALUE_W-1:0]  ring_wdata;
	logic [CW-1:0]       sp_dec;

	assign out_free  = !out_valid_q || m_tready;
	assign cmd_ready = (state_q == S_IDLE) && out_free;
	assign sp_dec    = sp_q - CW'(1);

	// Execute one request
	always_comb begin
		state_nxt   = state_q;
		head_nxt    = head_q;
		tail_nxt    = tail_q;
		count_nxt   = count_q;
		left_nxt    = left_q;
		sp_nxt      = sp_q;
		rdv_nxt     = 1'b0;
		load_out    = 1'b0;
		res_removed = '0;
		res_status  = STAT_OK;
		ring_we     = 1'b0;
		ring_re     = 1'b0;
		stack_we    = 1'b0;
		stack_re    = 1'b0;
		ring_waddr  = tail_q;
		ring_wdata  = cmd.value;
		ring_raddr  = head_q;
		stack_waddr = sp_q[PW-1:0];
		stack_raddr = sp_dec[PW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && out_free) begin
					unique case (cmd.op)
						OP_INSERT: begin
							load_out = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								res_status = STAT_OVERFLOW;
							end else begin
								ring_we   = 1'b1;
								tail_nxt  = adv(tail_q);
								count_nxt = count_q + CW'(1);
							end
						end
						OP_REMOVE: begin
							if (count_q == '0) begin
								load_out   = 1'b1;
								res_status = STAT_EMPTY;
							end else begin
								ring_re   = 1'b1;
								head_nxt  = adv(head_q);
								count_nxt = count_q - CW'(1);
								state_nxt = S_RDATA;
							end
						end
						OP_REVERSE: begin
							priority if (count_q == '0) begin
								load_out   = 1'b1;
								res_status = STAT_EMPTY;
							end else if (KW'(cmd.count) > KW'(count_q)) begin
								load_out   = 1'b1;
								res_status = STAT_EXCEED;
							end else if (cmd.count_zero) begin
								load_out = 1'b1;
							end else begin
								left_nxt  = CW'(cmd.count);
								sp_nxt    = '0;
								state_nxt = S_PUSH;
							end
						end
						OP_NOP: begin
							load_out = 1'b1;
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			S_RDATA: begin
				load_out    = 1'b1;
				res_removed = ring_rdata_q;
				state_nxt   = S_IDLE;
			end
			S_PUSH: begin
				// Read head entries, write each onto the stack in the cycle after its read
				if (left_q != '0) begin
					ring_re  = 1'b1;
					head_nxt = adv(head_q);
					left_nxt = left_q - CW'(1);
					rdv_nxt  = 1'b1;
				end
				if (rdv_s1) begin
					stack_we = 1'b1;
					sp_nxt   = sp_q + CW'(1);
				end
				if (left_q == '0 && !rdv_s1) begin
					state_nxt = S_POP;
				end
			end
			S_POP: begin
				// Pop the stack, append each word at the tail
				ring_wdata = stack_rdata_q;
				if (sp_q != '0) begin
					stack_re = 1'b1;
					sp_nxt   = sp_dec;
					rdv_nxt  = 1'b1;
				end
				if (rdv_s1) begin
					ring_we  = 1'b1;
					tail_nxt = adv(tail_q);
				end
				if (sp_q == '0 && !rdv_s1) begin
					load_out  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			left_q      <= '0;
			sp_q        <= '0;
			rdv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			head_q  <= head_nxt;
			tail_q  <= tail_nxt;
			count_q <= count_nxt;
			left_q  <= left_nxt;
			sp_q    <= sp_nxt;
			rdv_s1  <= rdv_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_removed_q <= res_removed;
			out_status_q  <= res_status;
			out_occ_q     <= OCC_W'(count_nxt);
		end
	end

	// Ring store
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= ring_wdata;
		end
		if (ring_re) begin
			ring_rdata_q <= ring_mem[ring_raddr];
		end
	end

	// Reverse stack
	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[stack_waddr] <= ring_rdata_q;
		end
		if (stack_re) begin
			stack_rdata_q <= stack_mem[stack_raddr];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_occ_q, out_status_q, out_removed_q};

endmodule

/* hdl/queue_partial_reverse_unit.sv */
`timescale 1ns / 1ps

// FIFO of signed 32-bit words with insert, remove and reverse-first-k commands.
// Input stream: s_tuser carries the command (0 insert, 1 remove, 2 reverse
// first k, 3 no-op); s_tdata carries the word to insert and the count k.
// Output stream: one result per request, with the removed word (zero unless a
// remove succeeded), a status (ok, overflow, empty, count too large) and the
// occupancy after the request.
// A front stage registers and decodes each request and hands it to a
// two-entry queue; the back end executes requests one at a time against the
// ring and stack memories, so the front keeps accepting while the back works.
// Back-end work per request: insert and every rejected request load their
// result in the accept cycle; a remove adds a registered ring read (S_RDATA);
// a reverse of k entries reads k head entries into the stack (S_PUSH), then
// pops them back to the tail (S_POP), each phase draining its registered read.
// From input accept, a request passes the front register and the queue entry
// before the back end takes it; the result comes from the output register.
// Reset clears the pointers, the occupancy, the queue and the output register;
// memory contents are left as they are and never read before being written.
// When the receiver stalls, the result is held and the back end stops before
// starting the next request; the queue then fills and s_tready drops.
module queue_partial_reverse_unit #(
	parameter int DEPTH = qpr_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [qpr_pkg::IN_TDATA_W-1:0]  s_tdata, // value[31:0], reverse_count[42:32], pad
	input  logic [qpr_pkg::MODE_W-1:0]      s_tuser, // mode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [qpr_pkg::OUT_TDATA_W-1:0] m_tdata // removed_value, status, occupancy, pad
);
	import qpr_pkg::*;

	logic front_valid, front_ready;
	cmd_t front_cmd;
	logic queue_valid, queue_ready;
	cmd_t queue_cmd;

	qpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	qpr_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_cmd    (front_cmd),
		.out_valid (queue_valid),
		.out_ready (queue_ready),
		.out_cmd   (queue_cmd)
	);

	qpr_engine #(
		.DEPTH (DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_valid),
		.cmd_ready (queue_ready),
		.cmd       (queue_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
